FILE: rtl/u2h_pkg.sv
// ----------------------------------------------------------------------------
// u2h_pkg: shared types, constants and the entity name table
// Holds the code point item type, character constants and the named entity
// lookup that the back end uses to spell out HTML entities.
// ----------------------------------------------------------------------------
package u2h_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned NameBytes  = 6;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChZero = 8'h30;

  // Entity codes: 0..95 are the Latin-1 block 160..255, the rest follow.
  localparam logic [6:0] EntQuot = 7'd96;
  localparam logic [6:0] EntLt   = 7'd97;
  localparam logic [6:0] EntGt   = 7'd98;
  localparam logic [6:0] EntAmp  = 7'd99;
  localparam logic [6:0] EntEuro = 7'd100;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] cp;
  } cp_item_t;

  // Entity name, right-aligned, zero bytes above it.
  function automatic logic [8*NameBytes-1:0] ent_name(input logic [6:0] code);
    logic [8*NameBytes-1:0] s;
    case (code)
      7'd0:  s = "nbsp";   7'd1:  s = "iexcl";  7'd2:  s = "cent";   7'd3:  s = "pound";
      7'd4:  s = "curren"; 7'd5:  s = "yen";    7'd6:  s = "brvbar"; 7'd7:  s = "sect";
      7'd8:  s = "uml";    7'd9:  s = "copy";   7'd10: s = "ordf";   7'd11: s = "laquo";
      7'd12: s = "not";    7'd13: s = "shy";    7'd14: s = "reg";    7'd15: s = "macr";
      7'd16: s = "deg";    7'd17: s = "plusmn"; 7'd18: s = "sup2";   7'd19: s = "sup3";
      7'd20: s = "acute";  7'd21: s = "micro";  7'd22: s = "para";   7'd23: s = "middot";
      7'd24: s = "cedil";  7'd25: s = "sup1";   7'd26: s = "ordm";   7'd27: s = "raquo";
      7'd28: s = "frac14"; 7'd29: s = "frac12"; 7'd30: s = "frac34"; 7'd31: s = "iquest";
      7'd32: s = "Agrave"; 7'd33: s = "Aacute"; 7'd34: s = "Acirc";  7'd35: s = "Atilde";
      7'd36: s = "Auml";   7'd37: s = "Aring";  7'd38: s = "AElig";  7'd39: s = "Ccedil";
      7'd40: s = "Egrave"; 7'd41: s = "Eacute"; 7'd42: s = "Ecirc";  7'd43: s = "Euml";
      7'd44: s = "Igrave"; 7'd45: s = "Iacute"; 7'd46: s = "Icirc";  7'd47: s = "Iuml";
      7'd48: s = "ETH";    7'd49: s = "Ntilde"; 7'd50: s = "Ograve"; 7'd51: s = "Oacute";
      7'd52: s = "Ocirc";  7'd53: s = "Otilde"; 7'd54: s = "Ouml";   7'd55: s = "times";
      7'd56: s = "Oslash"; 7'd57: s = "Ugrave"; 7'd58: s = "Uacute"; 7'd59: s = "Ucirc";
      7'd60: s = "Uuml";   7'd61: s = "Yacute"; 7'd62: s = "THORN";  7'd63: s = "szlig";
      7'd64: s = "agrave"; 7'd65: s = "aacute"; 7'd66: s = "acirc";  7'd67: s = "atilde";
      7'd68: s = "auml";   7'd69: s = "aring";  7'd70: s = "aelig";  7'd71: s = "ccedil";
      7'd72: s = "egrave"; 7'd73: s = "eacute"; 7'd74: s = "ecirc";  7'd75: s = "euml";
      7'd76: s = "igrave"; 7'd77: s = "iacute"; 7'd78: s = "icirc";  7'd79: s = "iuml";
      7'd80: s = "eth";    7'd81: s = "ntilde"; 7'd82: s = "ograve"; 7'd83: s = "oacute";
      7'd84: s = "ocirc";  7'd85: s = "otilde"; 7'd86: s = "ouml";   7'd87: s = "divide";
      7'd88: s = "oslash"; 7'd89: s = "ugrave"; 7'd90: s = "uacute"; 7'd91: s = "ucirc";
      7'd92: s = "uuml";   7'd93: s = "yacute"; 7'd94: s = "thorn";  7'd95: s = "yuml";
      EntQuot: s = "quot";
      EntLt:   s = "lt";
      EntGt:   s = "gt";
      EntAmp:  s = "amp";
      EntEuro: s = "euro";
      default: s = "amp";
    endcase
    return s;
  endfunction

  // Number of characters in a name: every non-zero byte counts.
  function automatic logic [2:0] ent_len(input logic [8*NameBytes-1:0] s);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < NameBytes; i++) begin
      if (s[8*i +: 8] != 8'h00) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/u2h_front.sv
// ----------------------------------------------------------------------------
// u2h_front: UTF-8 sequence decoder
// Takes bytes, gathers multi-byte sequences and pushes finished code points.
// ----------------------------------------------------------------------------
module u2h_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  output u2h_pkg::cp_item_t    push_o
);

  logic [u2h_pkg::CpW-1:0] accum_q, accum_d;
  logic [1:0]              pend_q, pend_d;

  always_comb begin
    accum_d      = accum_q;
    pend_d       = pend_q;
    push_o.valid = 1'b0;
    push_o.cp    = accum_q;
    if (accept_i) begin
      if (pend_q != 2'd0) begin
        accum_d      = {accum_q[u2h_pkg::CpW-7:0], in_byte_i[5:0]};
        pend_d       = pend_q - 2'd1;
        push_o.valid = (pend_q == 2'd1);
        push_o.cp    = accum_d;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        accum_d = {{(u2h_pkg::CpW-3){1'b0}}, in_byte_i[2:0]};
        pend_d  = 2'd3;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        accum_d = {{(u2h_pkg::CpW-4){1'b0}}, in_byte_i[3:0]};
        pend_d  = 2'd2;
      end else if (in_byte_i[7:5] == 3'b110) begin
        accum_d = {{(u2h_pkg::CpW-5){1'b0}}, in_byte_i[4:0]};
        pend_d  = 2'd1;
      end else if (!in_byte_i[7]) begin
        accum_d      = {{(u2h_pkg::CpW-8){1'b0}}, in_byte_i};
        push_o.valid = 1'b1;
        push_o.cp    = accum_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      pend_q  <= 2'd0;
    end else begin
      accum_q <= accum_d;
      pend_q  <= pend_d;
    end
  end

endmodule

FILE: rtl/u2h_fifo.sv
// ----------------------------------------------------------------------------
// u2h_fifo: code point queue
// A small queue that parts the decoder from the character generator.
// ----------------------------------------------------------------------------
module u2h_fifo #(
  parameter int unsigned Depth = u2h_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u2h_pkg::cp_item_t push_i,
  input  logic              pop_i,
  output u2h_pkg::cp_item_t head_o,
  output logic              full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [u2h_pkg::CpW-1:0] mem_q [Depth];
  logic [PtrW-1:0]         wr_q, rd_q;
  logic [CntW-1:0]         cnt_q;
  logic                    do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cp    = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/u2h_back.sv
// ----------------------------------------------------------------------------
// u2h_back: character generator
// Turns each queued code point into ASCII characters: passes printable text,
// spells named entities, drops U+FFFD, converts others to decimal references.
// ----------------------------------------------------------------------------
module u2h_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u2h_pkg::cp_item_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              out_last_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SName = 2'd1;
  localparam logic [1:0] SConv = 2'd2;
  localparam logic [1:0] SDec  = 2'd3;
  localparam int unsigned NW   = 8 * u2h_pkg::NameBytes;
  localparam int unsigned Nd   = 7;

  logic [1:0]              state_q, state_d;
  logic [u2h_pkg::CpW-1:0] cp_q, cp_d;
  logic [NW-1:0]           name_q, name_d;
  logic [2:0]              len_q, len_d;
  logic [2:0]              pos_q, pos_d;
  logic [2:0]              nd_q, nd_d;
  logic [3:0]              dig_q [Nd];
  logic                    dig_we;

  logic                    ov_q;
  logic [7:0]              oc_q;
  logic                    ol_q;
  logic                    out_ready;
  logic                    emit, emit_last;
  logic [7:0]              emit_char;

  // Head classification.
  logic [u2h_pkg::CpW-1:0] hc;
  logic [6:0]              hcode;
  logic                    h_named, h_print, h_repl;
  logic [7:0]              lat_idx;
  logic [NW-1:0]           h_name;
  logic [2:0]              h_len;

  // Divide by ten through a reciprocal: exact for values below 2^22.
  logic [44:0]             prod;
  logic [u2h_pkg::CpW-1:0] quo;
  logic [24:0]             quo10;
  logic [24:0]             rem_full;

  assign out_ready = !ov_q || !out_stall_i;

  always_comb begin
    hc      = head_i.cp;
    lat_idx = hc[7:0] - 8'd160;
    h_named = 1'b1;
    hcode   = lat_idx[6:0];
    if (hc == 21'h22) begin
      hcode = u2h_pkg::EntQuot;
    end else if (hc == 21'h3C) begin
      hcode = u2h_pkg::EntLt;
    end else if (hc == 21'h3E) begin
      hcode = u2h_pkg::EntGt;
    end else if (hc == 21'h26) begin
      hcode = u2h_pkg::EntAmp;
    end else if (hc >= 21'd160 && hc <= 21'd255) begin
      hcode = lat_idx[6:0];
    end else if (hc == 21'd8364) begin
      hcode = u2h_pkg::EntEuro;
    end else begin
      h_named = 1'b0;
    end
    h_print = !h_named && hc >= 21'h20 && hc <= 21'h7E;
    h_repl  = (hc == 21'd65533);
    h_name  = u2h_pkg::ent_name(hcode);
    h_len   = u2h_pkg::ent_len(h_name);
  end

  always_comb begin
    prod     = {24'd0, cp_q} * 45'd1677722;
    quo      = prod[44:24];
    quo10    = {1'b0, quo, 3'b000} + {3'b000, quo, 1'b0};
    rem_full = {4'd0, cp_q} - quo10;
  end

  always_comb begin
    state_d   = state_q;
    cp_d      = cp_q;
    name_d    = name_q;
    len_d     = len_q;
    pos_d     = pos_q;
    nd_d      = nd_q;
    dig_we    = 1'b0;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = u2h_pkg::ChSemi;
    case (state_q)
      SIdle: begin
        if (head_i.valid) begin
          if (h_named) begin
            pop_o   = 1'b1;
            name_d  = h_name << (8 * (3'd6 - h_len));
            len_d   = h_len;
            pos_d   = 3'd0;
            state_d = SName;
          end else if (h_print) begin
            if (out_ready) begin
              pop_o     = 1'b1;
              emit      = 1'b1;
              emit_last = 1'b1;
              emit_char = hc[7:0];
            end
          end else if (h_repl) begin
            pop_o = 1'b1;
          end else begin
            pop_o   = 1'b1;
            cp_d    = hc;
            nd_d    = 3'd0;
            state_d = SConv;
          end
        end
      end
      SName: begin
        if (out_ready) begin
          emit  = 1'b1;
          pos_d = pos_q + 3'd1;
          if (pos_q == 3'd0) begin
            emit_char = u2h_pkg::ChAmp;
          end else if (pos_q <= len_q) begin
            emit_char = name_q[NW-1 -: 8];
            name_d    = name_q << 8;
          end else begin
            emit_last = 1'b1;
            state_d   = SIdle;
          end
        end
      end
      SConv: begin
        dig_we = 1'b1;
        cp_d   = quo;
        nd_d   = nd_q + 3'd1;
        if (quo == '0 || nd_q == 3'(Nd - 1)) begin
          pos_d   = 3'd0;
          state_d = SDec;
        end
      end
      SDec: begin
        if (out_ready) begin
          emit = 1'b1;
          if (pos_q == 3'd0) begin
            emit_char = u2h_pkg::ChAmp;
            pos_d     = 3'd1;
          end else if (pos_q == 3'd1) begin
            emit_char = u2h_pkg::ChHash;
            pos_d     = 3'd2;
          end else if (nd_q != 3'd0) begin
            emit_char = u2h_pkg::ChZero + {4'd0, dig_q[nd_q - 3'd1]};
            nd_d      = nd_q - 3'd1;
          end else begin
            emit_last = 1'b1;
            state_d   = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_q[nd_q] <= rem_full[3:0];
    end
    cp_q   <= cp_d;
    name_q <= name_d;
    len_q  <= len_d;
    pos_q  <= pos_d;
    if (emit) begin
      oc_q <= emit_char;
      ol_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      nd_q    <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      nd_q    <= nd_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;

endmodule

FILE: rtl/utf8_to_html_entity_encoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_html_entity_encoder_unit: UTF-8 to HTML text encoder
// Decodes a UTF-8 byte stream and writes it out as HTML-safe ASCII.
// ----------------------------------------------------------------------------
// The block takes one byte of UTF-8 text per item and gives one ASCII
// character per output item, with out_last_o high on the final character of
// each code point. The decoder accepts a byte in every cycle while its queue
// has room, so the input rate is one byte per cycle for as long as the
// character generator keeps up. Printable ASCII leaves at one character per
// cycle while the receiver does not stall. A named entity first takes the
// code point from the queue, then sends the ampersand, each letter of the
// name and the semicolon. A decimal reference leaves the queue, has its
// digits produced one by one in the divide-by-ten unit, then sends the
// ampersand, the hash, every digit and the semicolon.
// The replacement character and stray continuation bytes produce nothing at
// all. The depth of the code point queue, set by QueueDepth, decides how
// many finished code points can wait while a long entity drains; once it is
// full the block raises in_stall_o. Every item flows with valid high and
// stall low; while a stalled receiver holds the current character in the
// result register the generator waits, though digit conversion goes on.
module utf8_to_html_entity_encoder_unit #(
  parameter int unsigned QueueDepth = u2h_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  u2h_pkg::cp_item_t push;
  u2h_pkg::cp_item_t head;
  logic              pop;
  logic              full;
  logic              accept;

  // A byte is taken whenever the queue has a free slot.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  u2h_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .push_o    (push)
  );

  u2h_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  u2h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

  // A code point is only pushed on a cycle when a byte was really taken.
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> accept)
    else $error("code point pushed without an accepted byte");

  // The generator never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from an empty queue");

  // Every character produced is printable ASCII.
  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o >= 8'h20 && out_char_o <= 8'h7E))
    else $error("non-printable character produced");

  // A semicolon only ever closes a code point's run.
  a_semi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |-> (out_char_o != u2h_pkg::ChSemi))
    else $error("semicolon inside a character run");

endmodule
